// ===== src/tlbla_pkg.sv =====
// Shared types and constants for the translation lookaside buffer with LFU aging.
package tlbla_pkg;

	localparam int LADDR_W = 16;
	localparam int FADDR_W = 24;
	localparam int PID_W   = 4;
	localparam int SLOT_W  = 3;
	localparam int USE_W   = 3;

	localparam logic [USE_W-1:0] USE_MAX = 3'd7;

	localparam logic KIND_XLATE = 1'b0;
	localparam logic KIND_APPEND = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [PID_W-1:0]   pid;
		logic [LADDR_W-1:0] logical_addr;
		logic [FADDR_W-1:0] frame_addr;
	} req_t;

	typedef struct packed {
		logic [FADDR_W-1:0] phys_addr;
		logic               tlb_hit;
		logic [SLOT_W-1:0]  slot;
		logic               table_full;
	} rsp_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} tlb_stat_t;

endpackage

// ===== src/tlbla_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module tlbla_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/tlbla_cnt.sv =====
// Per-process page-table fill counts: RAM with per-entry valid flags cleared at reset.
module tlbla_cnt #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4,
	parameter int CNT_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [CNT_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [CNT_W-1:0] wr_data
);

	logic [CNT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [CNT_W-1:0] data_q;
	logic             data_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			data_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				data_vld_q <= vld_q[rd_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_idx];
		end
	end

	assign rd_data = data_vld_q ? data_q : '0;

endmodule

// ===== src/tlbla_tlb.sv =====
// TLB slots: associative lookup, LFU victim choice with ageing, hit and refill update.
module tlbla_tlb #(
	parameter int ENTRIES = 8,
	parameter int PAGE_W  = 8,
	parameter int FRAME_W = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [tlbla_pkg::PID_W-1:0]    pid,
	input  logic [PAGE_W-1:0]              page,
	input  logic                           commit,
	input  logic [FRAME_W-1:0]             miss_frame,
	output tlbla_pkg::tlb_stat_t           stat,
	output logic [FRAME_W-1:0]             hit_frame
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int USE_W = tlbla_pkg::USE_W;
	localparam int USE_LEVELS = 1 << USE_W;

	logic [ENTRIES-1:0]          valid_q;
	logic [tlbla_pkg::PID_W-1:0] owner_q [ENTRIES];
	logic [PAGE_W-1:0]           page_q  [ENTRIES];
	logic [FRAME_W-1:0]          frame_q [ENTRIES];
	logic [USE_W-1:0]            use_q   [ENTRIES];

	logic                  hit;
	logic [IDX_W-1:0]      hit_idx;
	logic                  inv_any;
	logic [IDX_W-1:0]      inv_idx;
	logic [USE_LEVELS-1:0] present;
	logic [USE_W-1:0]      least;
	logic [IDX_W-1:0]      victim_idx;
	logic [IDX_W-1:0]      fill_idx;

	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		inv_any    = 1'b0;
		inv_idx    = '0;
		present    = '0;
		least      = '0;
		victim_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && owner_q[i] == pid && page_q[i] == page) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				inv_any = 1'b1;
				inv_idx = IDX_W'(i);
			end
		end
		for (int c = 0; c < USE_LEVELS; c++) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (use_q[i] == USE_W'(c)) begin
					present[c] = 1'b1;
				end
			end
		end
		for (int c = USE_LEVELS - 1; c >= 0; c--) begin
			if (present[c]) begin
				least = USE_W'(c);
			end
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (use_q[i] == least) begin
				victim_idx = IDX_W'(i);
			end
		end
	end

	assign fill_idx  = inv_any ? inv_idx : victim_idx;
	assign hit_frame = frame_q[hit_idx];
	assign stat.hit  = hit;
	assign stat.slot = hit ? tlbla_pkg::SLOT_W'(hit_idx) : tlbla_pkg::SLOT_W'(fill_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				use_q[i] <= '0;
			end
		end else if (commit) begin
			if (hit) begin
				use_q[hit_idx] <= tlbla_pkg::USE_MAX;
			end else begin
				// refilled slot restarts at the top, the others age when nothing is free
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == fill_idx) begin
						use_q[i] <= tlbla_pkg::USE_MAX;
					end else if (!inv_any && use_q[i] != '0) begin
						use_q[i] <= use_q[i] - USE_W'(1);
					end
				end
				valid_q[fill_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && !hit) begin
			owner_q[fill_idx] <= pid;
			page_q[fill_idx]  <= page;
			frame_q[fill_idx] <= miss_frame;
		end
	end

endmodule

// ===== src/tlb_translate_lfu_aging.sv =====
// Top level: address translation with per-process page tables and an LFU-ageing TLB.
// Flow: a request is registered when accepted; its result is registered when it commits,
// after the registered reads of the page-table RAM and the fill-count RAM. A new
// transaction is not accepted until the current one commits.
// A waiting result stalls the commit only; the next transaction is taken once it commits.
// Reset: TLB valid flags and fill counts clear at once; page-table entries past a
// process's fill count read as zero, so the page table needs no clearing pass.
module tlb_translate_lfu_aging #(
	parameter int TLB_ENTRIES    = 8,
	parameter int PAGES_PER_PROC = 256,
	parameter int OFFSET_BITS    = 8,
	parameter int PROC_COUNT     = 16,
	parameter int PHYS_ADDR_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tlbla_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output tlbla_pkg::rsp_t rsp
);

	localparam int LADDR_W    = tlbla_pkg::LADDR_W;
	localparam int FADDR_W    = tlbla_pkg::FADDR_W;
	localparam int PAGE_W     = LADDR_W - OFFSET_BITS;
	localparam int FRAME_W    = FADDR_W - OFFSET_BITS;
	localparam int CNT_W      = $clog2(PAGES_PER_PROC + 1);
	localparam int PROC_IDX_W = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
	localparam int PT_DEPTH   = PROC_COUNT * PAGES_PER_PROC;
	localparam int PT_AW      = $clog2(PT_DEPTH);
	localparam int CMP_W      = 17;
	localparam logic [FADDR_W-1:0] PHYS_MASK =
		FADDR_W'((64'(1) << PHYS_ADDR_BITS) - 64'(1));

	tlbla_pkg::req_t      req_q;
	logic                 pid_ok_q;
	logic                 busy_q;
	tlbla_pkg::rsp_t      rsp_q;
	logic                 rsp_valid_q;

	logic                 accept;
	logic [PAGE_W-1:0]    page_in;
	logic                 pid_ok_in;
	logic                 page_ok_in;
	logic [PT_AW-1:0]     pt_rd_addr;

	logic                 commit;
	logic [PAGE_W-1:0]    page_cur;
	logic [CNT_W-1:0]     cnt_rd;
	logic [CNT_W-1:0]     cnt_eff;
	logic                 full;
	logic [PT_AW-1:0]     pt_wr_addr;
	logic [FRAME_W-1:0]   pt_rd;
	logic [FRAME_W-1:0]   miss_frame;
	logic [FRAME_W-1:0]   hit_frame;
	logic [FRAME_W-1:0]   frame;
	tlbla_pkg::tlb_stat_t tstat;
	logic                 is_append;

	assign req_ready = !busy_q;
	assign accept    = req_valid && req_ready;

	assign page_in    = req.logical_addr[LADDR_W-1:OFFSET_BITS];
	assign pid_ok_in  = CMP_W'(req.pid) < CMP_W'(PROC_COUNT);
	assign page_ok_in = CMP_W'(page_in) < CMP_W'(PAGES_PER_PROC);
	assign pt_rd_addr = PT_AW'(PT_AW'(req.pid) * PT_AW'(PAGES_PER_PROC) + PT_AW'(page_in));

	assign is_append  = req_q.kind == tlbla_pkg::KIND_APPEND;
	assign commit     = busy_q && (!rsp_valid_q || rsp_ready);
	assign page_cur   = req_q.logical_addr[LADDR_W-1:OFFSET_BITS];
	assign cnt_eff    = pid_ok_q ? cnt_rd : '0;
	assign full       = !pid_ok_q || (cnt_eff >= CNT_W'(PAGES_PER_PROC));
	assign pt_wr_addr = PT_AW'(PT_AW'(req_q.pid) * PT_AW'(PAGES_PER_PROC) + PT_AW'(cnt_eff));
	// entries at or beyond the fill count were never written and read as zero
	assign miss_frame = (CMP_W'(page_cur) < CMP_W'(cnt_eff)) ? pt_rd : '0;
	assign frame      = tstat.hit ? hit_frame : miss_frame;

	tlbla_ram #(
		.DEPTH (PT_DEPTH),
		.AW    (PT_AW),
		.DW    (FRAME_W)
	) u_pt (
		.clk     (clk),
		.wr_en   (commit && is_append && !full),
		.wr_addr (pt_wr_addr),
		.wr_data (req_q.frame_addr[FADDR_W-1:OFFSET_BITS]),
		.rd_en   (accept && req.kind == tlbla_pkg::KIND_XLATE && pid_ok_in && page_ok_in),
		.rd_addr (pt_rd_addr),
		.rd_data (pt_rd)
	);

	tlbla_cnt #(
		.DEPTH (PROC_COUNT),
		.IDX_W (PROC_IDX_W),
		.CNT_W (CNT_W)
	) u_cnt (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && pid_ok_in),
		.rd_idx  (PROC_IDX_W'(req.pid)),
		.rd_data (cnt_rd),
		.wr_en   (commit && is_append && !full),
		.wr_idx  (PROC_IDX_W'(req_q.pid)),
		.wr_data (CNT_W'(cnt_eff + CNT_W'(1)))
	);

	tlbla_tlb #(
		.ENTRIES (TLB_ENTRIES),
		.PAGE_W  (PAGE_W),
		.FRAME_W (FRAME_W)
	) u_tlb (
		.clk        (clk),
		.arst_n     (arst_n),
		.pid        (req_q.pid),
		.page       (page_cur),
		.commit     (commit && !is_append),
		.miss_frame (miss_frame),
		.stat       (tstat),
		.hit_frame  (hit_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req;
			pid_ok_q <= pid_ok_in;
		end
		if (commit) begin
			if (is_append) begin
				rsp_q.phys_addr  <= '0;
				rsp_q.tlb_hit    <= 1'b0;
				rsp_q.slot       <= '0;
				rsp_q.table_full <= full;
			end else begin
				rsp_q.phys_addr  <= {frame, req_q.logical_addr[OFFSET_BITS-1:0]} & PHYS_MASK;
				rsp_q.tlb_hit    <= tstat.hit;
				rsp_q.slot       <= tstat.slot;
				rsp_q.table_full <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
